FILE: hdl/tpnuc_pkg.sv
// ----------------------------------------------------------------------------
// tpnuc_pkg: shared types and constants
// Types, mode codes and sizes for the two-point correction block.
// ----------------------------------------------------------------------------
package tpnuc_pkg;

	localparam int unsigned PIXELS_DEF    = 65536;
	localparam int unsigned FRAC_BITS_DEF = 14;
	localparam int unsigned SUM_W         = 24;
	localparam int unsigned COEF_W        = 32;
	localparam int unsigned PIX_W         = 16;
	localparam int unsigned IDX_W         = 16;
	localparam int unsigned FC_W          = 9;
	localparam logic [15:0] FULL_SCALE    = 16'hFFFF;

	typedef enum logic [2:0] {
		MODE_CLEAR   = 3'd0,
		MODE_ADD_LO  = 3'd1,
		MODE_ADD_HI  = 3'd2,
		MODE_COMPUTE = 3'd3,
		MODE_CORRECT = 3'd4
	} mode_t;

	localparam logic CFG_FRAME_COUNT = 1'b0;
	localparam logic CFG_ENABLE      = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_DIV,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

	// Request to and answer from the shared divider.
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [25:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

endpackage

FILE: hdl/tpnuc_divider.sv
// ----------------------------------------------------------------------------
// tpnuc_divider: radix-2 restoring divider
// Divides a 64-bit magnitude by a 26-bit magnitude, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpnuc_divider
	import tpnuc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [63:0] quo_q;
	logic [26:0] rem_q;
	logic [25:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [27:0] trial;

	assign trial = {rem_q, quo_q[63]} - {2'b00, den_q};

	// Shift in one numerator bit per cycle and subtract when it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[27]) begin
				rem_q <= trial[26:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[25:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	// Completion must follow each start.
	a_done_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> ##65 done_q) else $error("divider done late");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start) else $error("divider restarted while busy");

endmodule

FILE: hdl/two_point_nuc_calibrate_correct_core.sv
// ----------------------------------------------------------------------------
// two_point_nuc_calibrate_correct_core: two-point sensor correction
// Per-pixel reference sums, coefficient computation and correction.
// ----------------------------------------------------------------------------
//  channel | signals                                         | dir
//  in      | in_valid, in_ready, mode, pixel_index, pixel_value | in
//  out     | out_valid, out_ready, corrected_value, coefficients_valid | out
//  cfg     | cfg_we, cfg_index, cfg_data                     | in
//
// Modes 0, 1, 2 and 4, and mode 3 on equal sums, pass through accept,
// memory read and execute.
// Mode 3 on unequal sums then runs two divisions, one after the other.
// One result may wait in the output register while the next transaction
// runs; a second finished result holds off the input until the first leaves.
// Reset clears every pixel entry, one entry per cycle, and no transaction
// is accepted during that clearing pass.
module two_point_nuc_calibrate_correct_core
	import tpnuc_pkg::*;
#(
	parameter int unsigned PIXELS    = PIXELS_DEF,
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        mode,
	input  logic [IDX_W-1:0]  pixel_index,
	input  logic [PIX_W-1:0]  pixel_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIX_W-1:0]  corrected_value,
	output logic              coefficients_valid,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [FC_W-1:0]   cfg_data
);

	localparam int unsigned AW    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int unsigned CW    = AW + 1;
	localparam int unsigned ENT_W = 2 * SUM_W + 2 * COEF_W + 1;

	// Pixel memory: low sum, high sum, gain, offset and valid bit per entry.
	logic [ENT_W-1:0] pix_mem [PIXELS];

	logic [SUM_W-1:0]  lo_rd_q, hi_rd_q;
	logic [COEF_W-1:0] gn_rd_q, of_rd_q;
	logic              vl_rd_q;

	logic [FC_W-1:0] frame_count_q;
	logic            enable_q;

	state_t state_q, state_d;
	logic [2:0]       mode_q;
	logic [AW-1:0]    addr_q;
	logic             inrange_q;
	logic [PIX_W-1:0] val_q;

	logic [CW-1:0] clr_q;
	logic          clearing;

	logic [PIX_W-1:0] out_val_q;
	logic             out_cv_q;
	logic             out_valid_q;

	// Coefficient work registers.
	logic [SUM_W:0]    dmag_q;
	logic              dneg_q;
	logic [SUM_W-1:0]  lsum_q;
	logic [COEF_W-1:0] gain_res_q;
	logic              second_q;

	div_req_t dreq;
	div_rsp_t drsp;

	logic              we_ent;
	logic [SUM_W-1:0]  wd_lo, wd_hi;
	logic [COEF_W-1:0] wd_gn, wd_of;
	logic              wd_vl;
	logic [AW-1:0]     waddr;

	logic fire_in, take_out;

	assign clearing = !clr_q[CW-1];
	assign fire_in  = in_valid && in_ready;
	assign take_out = out_valid_q && out_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FC_W'(16);
			enable_q      <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_COUNT: frame_count_q <= cfg_data;
				CFG_ENABLE:      enable_q <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	// Entry clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (clearing)
			clr_q <= (clr_q[AW-1:0] == AW'(PIXELS - 1)) ? {1'b1, {AW{1'b0}}} : clr_q + 1'b1;
	end

	// Control state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Output register: may hold one result while the next transaction runs.
	logic load_out;
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		dreq.start = 1'b0;
		dreq.num = '0;
		dreq.den = 26'(dmag_q);
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = !clearing;
				if (fire_in) state_d = ST_READ;
			end
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: begin
				if (mode_q == MODE_COMPUTE && inrange_q && hi_rd_q != lo_rd_q)
					state_d = ST_DIV;
				else if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end else
					state_d = ST_OUT;
			end
			ST_DIV: begin
				dreq.start = 1'b1;
				dreq.num = second_q
					? ({23'd0, 41'({lsum_q, 16'd0}) - 41'(lsum_q)} << 1) | 64'd0
					: (64'(41'(frame_count_q) * 41'(FULL_SCALE)) << (FRAC_BITS + 1));
				dreq.num = dreq.num + 64'(dmag_q);
				dreq.den = {dmag_q, 1'b0};
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (drsp.done) begin
					if (!second_q) state_d = ST_DIV;
					else if (!out_valid_q || out_ready) begin
						load_out = 1'b1;
						state_d = ST_IDLE;
					end else state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	tpnuc_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Input capture.
	always_ff @(posedge clk) begin
		if (fire_in) begin
			mode_q    <= mode;
			addr_q    <= AW'(pixel_index);
			inrange_q <= (32'(pixel_index) < PIXELS);
			val_q     <= pixel_value;
		end
	end

	// Memory read, registered on acceptance.
	always_ff @(posedge clk) begin
		if (fire_in)
			{lo_rd_q, hi_rd_q, gn_rd_q, of_rd_q, vl_rd_q} <= pix_mem[AW'(pixel_index)];
	end

	// Saturated rounded quotient.
	function automatic logic [COEF_W-1:0] sat_q(input logic [63:0] q, input logic neg);
		logic [COEF_W-1:0] r;
		if (neg) r = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
		else     r = (q >  64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
		return r;
	endfunction

	// Correction datapath.
	logic signed [48:0] prod;
	logic signed [48:0] scaled;
	logic signed [49:0] sumv;
	logic [PIX_W-1:0]   corr;
	logic [SUM_W:0]     lo_add, hi_add;
	assign prod   = $signed(gn_rd_q) * $signed({1'b0, val_q});
	assign scaled = prod >>> FRAC_BITS;
	assign sumv   = 50'(scaled) + 50'($signed(of_rd_q));
	assign corr   = sumv[49] ? '0 : (sumv > 50'sd65535) ? 16'hFFFF : sumv[15:0];
	assign lo_add = {1'b0, lo_rd_q} + (SUM_W + 1)'(val_q);
	assign hi_add = {1'b0, hi_rd_q} + (SUM_W + 1)'(val_q);

	// Write-back selection: fields that a mode leaves alone keep their read value.
	always_comb begin
		we_ent = 1'b0;
		wd_lo = lo_rd_q; wd_hi = hi_rd_q; wd_gn = gn_rd_q; wd_of = of_rd_q;
		wd_vl = vl_rd_q;
		waddr = addr_q;
		if (clearing) begin
			we_ent = 1'b1;
			wd_lo = '0; wd_hi = '0; wd_gn = '0; wd_of = '0; wd_vl = 1'b0;
			waddr = clr_q[AW-1:0];
		end else if (state_q == ST_EXEC && inrange_q) begin
			unique case (mode_q)
				MODE_CLEAR: begin
					we_ent = 1'b1;
					wd_lo = '0; wd_hi = '0; wd_vl = 1'b0;
				end
				MODE_ADD_LO: begin
					we_ent = 1'b1;
					wd_lo = lo_add[SUM_W] ? '1 : lo_add[SUM_W-1:0];
				end
				MODE_ADD_HI: begin
					we_ent = 1'b1;
					wd_hi = hi_add[SUM_W] ? '1 : hi_add[SUM_W-1:0];
				end
				MODE_COMPUTE: begin
					if (hi_rd_q == lo_rd_q) begin
						we_ent = 1'b1; wd_vl = 1'b1;
						wd_gn = COEF_W'(1) << FRAC_BITS;
						wd_of = '0;
					end
				end
				default: ;
			endcase
		end else if (state_q == ST_DIV_WAIT && drsp.done && second_q) begin
			we_ent = 1'b1; wd_vl = 1'b1;
			wd_gn = gain_res_q;
			wd_of = sat_q(drsp.quo, !dneg_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we_ent) pix_mem[waddr] <= {wd_lo, wd_hi, wd_gn, wd_of, wd_vl};
	end

	// Coefficient work registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			dneg_q   <= hi_rd_q < lo_rd_q;
			dmag_q   <= (hi_rd_q < lo_rd_q) ? {1'b0, lo_rd_q - hi_rd_q}
				: {1'b0, hi_rd_q - lo_rd_q};
			lsum_q   <= lo_rd_q;
			second_q <= 1'b0;
		end else if (state_q == ST_DIV_WAIT && drsp.done && !second_q) begin
			gain_res_q <= sat_q(drsp.quo, dneg_q);
			second_q   <= 1'b1;
		end
	end

	// Result value for the executing transaction.
	logic [PIX_W-1:0] res_val;
	logic             res_cv;
	always_comb begin
		res_val = '0;
		res_cv  = 1'b0;
		if (inrange_q) begin
			unique case (mode_q)
				MODE_CLEAR:   res_cv = 1'b0;
				MODE_COMPUTE: res_cv = 1'b1;
				MODE_CORRECT: begin
					res_cv  = vl_rd_q;
					res_val = (enable_q && vl_rd_q) ? corr : val_q;
				end
				default: res_cv = vl_rd_q;
			endcase
		end else if (mode_q == MODE_CORRECT)
			res_val = val_q;
	end

	logic [PIX_W-1:0] pend_val_q;
	logic             pend_cv_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			pend_val_q <= res_val;
			pend_cv_q  <= res_cv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (take_out)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_val_q <= (state_q == ST_EXEC) ? res_val : pend_val_q;
			out_cv_q  <= (state_q == ST_EXEC) ? res_cv : pend_cv_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign corrected_value    = out_val_q;
	assign coefficients_valid = out_cv_q;

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_ready) else $error("accept during clearing pass");
	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire_in |=> state_q == ST_READ) else $error("read stage skipped");
	a_load_ok: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || out_ready)) else $error("result overwritten");

endmodule

FILE: test/tb_two_point_nuc_calibrate_correct_core.sv
// ----------------------------------------------------------------------------
// tb_two_point_nuc_calibrate_correct_core: self-checking testbench
// Drives calibration sequences (clear, low and high sums, coefficient
// compute, correction) and noise into the core with random bursts and
// output stalls. A behavioral predictor forecasts every result, and a monitor
// compares each output transaction field by field, across several settings.
// ----------------------------------------------------------------------------
module tb_two_point_nuc_calibrate_correct_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tpnuc_pkg::*;

	localparam int STALL_LIMIT = 300000;

	typedef struct {
		logic [2:0]  op;
		logic [15:0] idx;
		logic [15:0] val;
	} pix_item_t;

	typedef struct {
		logic [15:0] value;
		logic        coef_ok;
	} pix_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] mode = 3'd0;
	logic [IDX_W-1:0] pixel_index = '0;
	logic [PIX_W-1:0] pixel_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PIX_W-1:0] corrected_value;
	logic coefficients_valid;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_FRAME_COUNT;
	logic [FC_W-1:0] cfg_data = '0;

	// Predictor state: per-pixel sums, coefficients and valid bits.
	logic [23:0] low_acc[int];
	logic [23:0] high_acc[int];
	logic signed [31:0] gain_mem[int];
	logic signed [31:0] offset_mem[int];
	bit pixel_ok[int];
	int unsigned frames_per_point = 16;
	bit correct_on = 1'b1;

	pix_item_t   pending_pixels[$];
	pix_result_t expected_pixels[$];
	bit          cleared[int];
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	logic [12:0] stall_pattern = 13'b1011001110001;
	bit          ready_free = 1'b0;

	two_point_nuc_calibrate_correct_core DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Round half away from zero and saturate to signed 32 bits.
	function automatic logic signed [31:0] round_sat(longint unsigned num,
			longint unsigned den, bit neg);
		longint unsigned q;
		q = (2 * num + den) / (2 * den);
		if (neg)
			return (q >= 64'd2147483648) ? 32'sh80000000 : -q[31:0];
		return (q > 64'd2147483647) ? 32'sh7fffffff : q[31:0];
	endfunction

	// Apply one accepted transaction to the predictor and return its result.
	function automatic pix_result_t predict_pixel(pix_item_t it);
		pix_result_t r;
		int i;
		logic [24:0] s;
		longint d;
		longint unsigned mag;
		longint prod;
		longint v;
		i = int'(it.idx);
		r.value = '0;
		case (it.op)
			MODE_CLEAR: begin
				low_acc[i] = '0;
				high_acc[i] = '0;
				pixel_ok[i] = 1'b0;
			end
			MODE_ADD_LO: begin
				s = low_acc[i] + it.val;
				low_acc[i] = s[24] ? 24'hFFFFFF : s[23:0];
			end
			MODE_ADD_HI: begin
				s = high_acc[i] + it.val;
				high_acc[i] = s[24] ? 24'hFFFFFF : s[23:0];
			end
			MODE_COMPUTE: begin
				d = longint'(high_acc[i]) - longint'(low_acc[i]);
				if (d == 0) begin
					gain_mem[i] = 32'sd1 <<< FRAC_BITS_DEF;
					offset_mem[i] = 0;
				end else begin
					mag = (d < 0) ? -d : d;
					gain_mem[i] = round_sat((64'd65535 * frames_per_point) << FRAC_BITS_DEF,
						mag, d < 0);
					offset_mem[i] = round_sat(64'd65535 * low_acc[i], mag, !(d < 0));
				end
				pixel_ok[i] = 1'b1;
			end
			MODE_CORRECT: begin
				if (correct_on && pixel_ok.exists(i) && pixel_ok[i]) begin
					prod = longint'(gain_mem[i]) * longint'({48'd0, it.val});
					v = (prod >>> FRAC_BITS_DEF) + longint'(offset_mem[i]);
					r.value = (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : v[15:0];
				end else begin
					r.value = it.val;
				end
			end
			default: ;
		endcase
		r.coef_ok = pixel_ok.exists(i) ? pixel_ok[i] : 1'b0;
		return r;
	endfunction

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				expected_pixels.insert(expected_pixels.size(),
					predict_pixel(pending_pixels[0]));
				pending_pixels.delete(0);
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_pixels.size() > 0) begin
				mode <= pending_pixels[0].op;
				pixel_index <= pending_pixels[0].idx;
				pixel_value <= pending_pixels[0].val;
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls on a rotating pattern, with free-running stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			stall_pattern <= {stall_pattern[0], stall_pattern[12:1]};
			if ($urandom_range(0, 199) == 0)
				ready_free <= !ready_free;
			out_ready <= ready_free | stall_pattern[0];
		end
	end

	// Monitor: compare each output transaction with the oldest prediction.
	always @(posedge clk) begin
		pix_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result value=%h coef_ok=%b", $time,
					corrected_value, coefficients_valid);
			end else begin
				exp_r = expected_pixels[0];
				expected_pixels.delete(0);
				if (corrected_value !== exp_r.value) begin
					mismatches++;
					$display("%0t: corrected_value expected %h actual %h", $time,
						exp_r.value, corrected_value);
				end
				if (coefficients_valid !== exp_r.coef_ok) begin
					mismatches++;
					$display("%0t: coefficients_valid expected %b actual %b", $time,
						exp_r.coef_ok, coefficients_valid);
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add_item(logic [2:0] op, logic [15:0] idx, logic [15:0] val);
		pix_item_t it;
		it.op = op;
		it.idx = idx;
		it.val = val;
		if (op == MODE_CLEAR)
			cleared[idx] = 1'b1;
		pending_pixels.insert(pending_pixels.size(), it);
	endtask

	// Well-formed calibration of one pixel with random content.
	task automatic calibrate_pixel(logic [15:0] idx, int n_lo, int n_hi, bit equal_sums);
		logic [15:0] v;
		add_item(MODE_CLEAR, idx, 16'($urandom));
		for (int k = 0; k < n_lo; k++) begin
			v = 16'($urandom);
			add_item(MODE_ADD_LO, idx, v);
			if (equal_sums)
				add_item(MODE_ADD_HI, idx, v);
		end
		if (!equal_sums)
			for (int k = 0; k < n_hi; k++)
				add_item(MODE_ADD_HI, idx, 16'($urandom));
		add_item(MODE_COMPUTE, idx, 16'($urandom));
		repeat ($urandom_range(1, 4))
			add_item(MODE_CORRECT, idx, 16'($urandom));
	endtask

	task automatic random_phase(int n_items);
		int target;
		logic [15:0] idx;
		int keys[$];
		target = pending_pixels.size() + n_items;
		while (pending_pixels.size() < target) begin
			case ($urandom_range(0, 9))
				0: add_item(MODE_CORRECT, 16'($urandom), 16'($urandom));
				1: add_item(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom));
				2: begin
					// Broken sequence on an already cleared pixel.
					keys.delete();
					foreach (cleared[k]) keys.insert(keys.size(), k);
					idx = 16'(keys[$urandom_range(0, keys.size() - 1)]);
					add_item(3'($urandom_range(MODE_ADD_LO, MODE_CORRECT)), idx,
						16'($urandom));
				end
				default: begin
					idx = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom);
					calibrate_pixel(idx, $urandom_range(1, 4), $urandom_range(1, 4),
						$urandom_range(0, 7) == 0);
				end
			endcase
		end
	endtask

	task automatic wait_idle();
		while (pending_pixels.size() != 0 || expected_pixels.size() != 0 || in_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [FC_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FRAME_COUNT)
			frames_per_point = 32'(data);
		else
			correct_on = data[0];
		@(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, every mode and the named corner cases.
		add_item(MODE_CORRECT, 16'd12345, 16'hFFFF);
		add_item(MODE_CLEAR, 16'd0, 16'd0);
		add_item(MODE_ADD_LO, 16'd0, 16'd0);
		add_item(MODE_ADD_HI, 16'd0, 16'hFFFF);
		add_item(MODE_COMPUTE, 16'd0, 16'd0);
		add_item(MODE_CORRECT, 16'd0, 16'd0);
		add_item(MODE_CORRECT, 16'd0, 16'hFFFF);
		add_item(MODE_ADD_LO, 16'd0, 16'h00FF);
		add_item(MODE_CORRECT, 16'd0, 16'h8000);
		add_item(MODE_CLEAR, 16'hFFFF, 16'hFFFF);
		add_item(MODE_ADD_LO, 16'hFFFF, 16'hFFFF);
		add_item(MODE_ADD_HI, 16'hFFFF, 16'd1);
		add_item(MODE_COMPUTE, 16'hFFFF, 16'd0);
		add_item(MODE_CORRECT, 16'hFFFF, 16'h1234);
		add_item(MODE_CLEAR, 16'd1, 16'd0);
		add_item(MODE_COMPUTE, 16'd1, 16'd0);
		add_item(MODE_CORRECT, 16'd1, 16'hABCD);
		add_item(3'd5, 16'd1, 16'hFFFF);
		add_item(3'd6, 16'd7, 16'd1);
		add_item(3'd7, 16'hFFFF, 16'd0);
		add_item(MODE_CLEAR, 16'd0, 16'd0);
		add_item(MODE_CORRECT, 16'd0, 16'h4321);
		wait_idle();

		// Sum saturation: more full-scale low samples than the sum can hold.
		add_item(MODE_CLEAR, 16'd2, 16'd0);
		repeat (260) add_item(MODE_ADD_LO, 16'd2, 16'hFFFF);
		add_item(MODE_ADD_HI, 16'd2, 16'd5);
		add_item(MODE_COMPUTE, 16'd2, 16'd0);
		add_item(MODE_CORRECT, 16'd2, 16'hFFFF);
		random_phase(60);
		wait_idle();

		write_reg(CFG_FRAME_COUNT, 9'd1);
		random_phase(70);
		wait_idle();
		write_reg(CFG_FRAME_COUNT, 9'd256);
		random_phase(70);
		wait_idle();
		write_reg(CFG_ENABLE, 9'd0);
		write_reg(CFG_FRAME_COUNT, 9'd0);
		random_phase(60);
		wait_idle();
		write_reg(CFG_ENABLE, 9'd1);
		random_phase(70);
		wait_idle();
		write_reg(CFG_FRAME_COUNT, 9'($urandom_range(1, 256)));
		random_phase(70);

		wait_idle();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/tpnuc_pkg.sv
hdl/tpnuc_divider.sv
hdl/two_point_nuc_calibrate_correct_core.sv
test/tb_two_point_nuc_calibrate_correct_core.sv
